// File: design/grr_pkg.sv
// ---------------------------------------------------------------------------
// grr_pkg
// Shared types and constants of the glyph row rasterizer.
// ---------------------------------------------------------------------------
package grr_pkg;

   localparam int GLYPH_SLOTS_DEFAULT  = 256;
   localparam int BITMAP_BYTES_DEFAULT = 16384;

   // request word kinds
   localparam logic [1:0] ACT_LOAD_GLYPH  = 2'd0;
   localparam logic [1:0] ACT_LOAD_BITMAP = 2'd1;
   localparam logic [1:0] ACT_DRAW        = 2'd2;

   // csr indexes
   localparam logic [1:0] CSR_FIRST_CODE   = 2'd0;
   localparam logic [1:0] CSR_LAST_CODE    = 2'd1;
   localparam logic [1:0] CSR_MIN_Y_OFFSET = 2'd2;
   localparam logic [1:0] CSR_PIXEL_COLOR  = 2'd3;

   localparam logic [7:0]  FIRST_CODE_RESET = 8'd32;
   localparam logic [7:0]  LAST_CODE_RESET  = 8'd126;
   localparam logic [15:0] SPACE_CODE       = 16'h0020;

   // glyph descriptor as stored in the glyph table, offset in the low bits
   typedef struct packed {
      logic [7:0]  y_offset;
      logic [7:0]  x_offset;
      logic [7:0]  advance;
      logic [7:0]  height;
      logic [7:0]  width;
      logic [15:0] bitmap_offset;
   } glyph_desc_type;

   localparam int GLYPH_DESC_BITS = $bits(glyph_desc_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_GLYPH,
      S_MUL,
      S_FETCH0,
      S_FETCH1,
      S_RUN
   } state_type;

endpackage

// File: design/grr_ram.sv
// ---------------------------------------------------------------------------
// grr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module grr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/glyph_row_rasterizer_unit.sv
// ---------------------------------------------------------------------------
// glyph_row_rasterizer_unit
// Renders one pixel row of a text string as line-buffer byte write masks.
// ---------------------------------------------------------------------------
// Glyph descriptors and bitmap bytes are loaded through the request stream
// (tuser kind 0 and 1). A draw word (kind 2) maps the character code into the
// glyph table, reads its descriptor, checks the row, multiplies width by the
// row within the glyph and, for a covered row, fetches two bitmap bytes, then
// sends one response word per line-buffer byte touched (1 to 33), or one empty
// word for an uncovered row; rsp_tready can hold each word. The byte walk is
// paced by the single read port of the bitmap RAM, which delivers at most one
// new byte per response word. The masks say which pixels to write; the pixel
// color register is left to the line-buffer writer. Stores have no reset: a
// glyph slot or bitmap byte must be loaded before a draw reads it.
module glyph_row_rasterizer_unit
   import grr_pkg::*;
#(
   parameter int GLYPH_SLOTS  = GLYPH_SLOTS_DEFAULT,
   parameter int BITMAP_BYTES = BITMAP_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // lsb up: table_index[15:0], glyph_bitmap_offset[31:16], glyph_width[39:32],
   // glyph_height[47:40], glyph_advance[55:48], glyph_x_offset[63:56],
   // glyph_y_offset[71:64], row[79:72]
   input  logic [79:0] req_tdata,
   // lsb up: action[1:0], string_start[2]
   input  logic [2:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // lsb up: byte_index[12:0], bit_mask[20:13], line_width[36:21], zero pad
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int GW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
   localparam int BW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
   localparam logic [16:0] GLYPH_LIMIT  = 17'(GLYPH_SLOTS);
   localparam logic [16:0] BITMAP_LIMIT = 17'(BITMAP_BYTES);

   // request fields
   logic [15:0] req_index;
   logic [15:0] req_offset;
   logic [7:0]  req_width;
   logic [7:0]  req_height;
   logic [7:0]  req_advance;
   logic [7:0]  req_xo;
   logic [7:0]  req_yo;
   logic [7:0]  req_row;
   logic [1:0]  req_action;
   logic        req_start;
   logic        req_fire;

   assign req_index   = req_tdata[15:0];
   assign req_offset  = req_tdata[31:16];
   assign req_width   = req_tdata[39:32];
   assign req_height  = req_tdata[47:40];
   assign req_advance = req_tdata[55:48];
   assign req_xo      = req_tdata[63:56];
   assign req_yo      = req_tdata[71:64];
   assign req_row     = req_tdata[79:72];
   assign req_action  = req_tuser[1:0];
   assign req_start   = req_tuser[2];
   assign req_fire    = req_tvalid && req_tready;

   // registers
   state_type      state_ff, state_in;
   logic [7:0]     first_code_ff, first_code_in;
   logic [7:0]     last_code_ff, last_code_in;
   logic [7:0]     min_y_ff, min_y_in;
   logic [15:0]    cursor_ff, cursor_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [12:0]    out_byte_ff, out_byte_in;
   logic [7:0]     out_mask_ff, out_mask_in;
   logic [15:0]    out_width_ff, out_width_in;
   logic           out_last_ff, out_last_in;
   logic           glyph_vld_ff, glyph_vld_in;
   logic [7:0]     row_ff, row_in;
   logic           end_ff, end_in;
   glyph_desc_type g_ff, g_in;
   logic           covered_ff, covered_in;
   logic [7:0]     rel_ff, rel_in;
   logic [15:0]    boff_ff, boff_in;
   logic [15:0]    pos_ff, pos_in;
   logic [7:0]     rem_ff, rem_in;
   logic [2:0]     sh_ff, sh_in;
   logic [7:0]     hi_ff, hi_in;
   logic [15:0]    rd_addr_ff, rd_addr_in;
   logic           rd_oob_ff, rd_oob_in;

   // memories
   logic                      gt_we;
   logic [GW-1:0]             gt_waddr;
   logic                      gt_re;
   logic [GW-1:0]             gt_raddr;
   logic [GLYPH_DESC_BITS-1:0] gt_rdata;
   logic                      bm_we;
   logic [BW-1:0]             bm_waddr;
   logic                      bm_re;
   logic [15:0]               bm_raddr;
   logic [7:0]                bm_rdata;

   glyph_desc_type            gt_wdesc;

   assign gt_wdesc = '{y_offset: req_yo, x_offset: req_xo, advance: req_advance,
                       height: req_height, width: req_width,
                       bitmap_offset: req_offset};

   grr_ram #(
      .WIDTH(GLYPH_DESC_BITS),
      .DEPTH(GLYPH_SLOTS)
   ) u_glyph_table (
      .clock  (clock),
      .wr_en  (gt_we),
      .wr_addr(gt_waddr),
      .wr_data(gt_wdesc),
      .rd_en  (gt_re),
      .rd_addr(gt_raddr),
      .rd_data(gt_rdata)
   );

   grr_ram #(
      .WIDTH(8),
      .DEPTH(BITMAP_BYTES)
   ) u_bitmap_store (
      .clock  (clock),
      .wr_en  (bm_we),
      .wr_addr(bm_waddr),
      .wr_data(req_width),
      .rd_en  (bm_re),
      .rd_addr(bm_raddr[BW-1:0]),
      .rd_data(bm_rdata)
   );

   // combinational helpers
   logic [15:0]    code;
   logic [15:0]    code_diff;
   logic           code_ok;
   glyph_desc_type g_rd;
   logic [9:0]     fl;
   logic [9:0]     fl_top;
   logic [9:0]     row_s;
   logic [9:0]     rel_full;
   logic [15:0]    xo16;
   logic [15:0]    adv16;
   logic [9:0]     wx;
   logic           overhang;
   logic [7:0]     lo_byte;
   logic [2:0]     pix;
   logic [3:0]     room;
   logic [3:0]     take;
   logic [15:0]    shifted;
   logic [7:0]     keep;
   logic [3:0]     sh_sum;
   logic           out_load;
   logic           take_last;

   assign req_tready = (state_ff == S_IDLE);
   assign out_load   = (state_ff == S_RUN) && (!rsp_valid_ff || rsp_tready);
   assign lo_byte    = rd_oob_ff ? 8'd0 : bm_rdata;

   always_comb begin
      // code mapping, space for anything outside the font
      code = req_index;
      if ((req_index < {8'd0, first_code_ff}) || (req_index > {8'd0, last_code_ff})) begin
         code = SPACE_CODE;
      end
      code_diff = code - {8'd0, first_code_ff};
      code_ok = (code >= {8'd0, first_code_ff}) && (code <= {8'd0, last_code_ff}) &&
                ({1'b0, code_diff} < GLYPH_LIMIT);

      g_rd     = glyph_vld_ff ? glyph_desc_type'(gt_rdata) : '0;
      fl       = {{2{g_rd.y_offset[7]}}, g_rd.y_offset} - {{2{min_y_ff[7]}}, min_y_ff};
      fl_top   = fl + {2'b00, g_rd.height};
      row_s    = {2'b00, row_ff};
      rel_full = row_s - fl;

      xo16     = {{8{g_ff.x_offset[7]}}, g_ff.x_offset};
      adv16    = {{8{g_ff.advance[7]}}, g_ff.advance};
      wx       = {2'b00, g_ff.width} + {{2{g_ff.x_offset[7]}}, g_ff.x_offset};
      overhang = $signed(wx) > $signed({{2{g_ff.advance[7]}}, g_ff.advance});

      pix     = pos_ff[2:0];
      room    = 4'd8 - {1'b0, pix};
      take    = ({4'd0, rem_ff} < {4'd0, room}) ? rem_ff[3:0] : room;
      shifted = {hi_ff, lo_byte} << sh_ff;
      keep    = 8'hFF << (4'd8 - take);
      sh_sum  = {1'b0, sh_ff} + take;
      take_last = (rem_ff == {4'd0, take});
   end

   always_comb begin
      state_in      = state_ff;
      first_code_in = first_code_ff;
      last_code_in  = last_code_ff;
      min_y_in      = min_y_ff;
      cursor_in     = cursor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_byte_in   = out_byte_ff;
      out_mask_in   = out_mask_ff;
      out_width_in  = out_width_ff;
      out_last_in   = out_last_ff;
      glyph_vld_in  = glyph_vld_ff;
      row_in        = row_ff;
      end_in        = end_ff;
      g_in          = g_ff;
      covered_in    = covered_ff;
      rel_in        = rel_ff;
      boff_in       = boff_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      sh_in         = sh_ff;
      hi_in         = hi_ff;
      rd_addr_in    = rd_addr_ff;
      rd_oob_in     = rd_oob_ff;
      gt_we         = 1'b0;
      gt_waddr      = req_index[GW-1:0];
      gt_re         = 1'b0;
      gt_raddr      = code_diff[GW-1:0];
      bm_we         = 1'b0;
      bm_waddr      = req_index[BW-1:0];
      bm_re         = 1'b0;
      bm_raddr      = rd_addr_ff + 16'd1;

      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_CODE:   first_code_in = csr_wdata;
            CSR_LAST_CODE:    last_code_in  = csr_wdata;
            CSR_MIN_Y_OFFSET: min_y_in      = csr_wdata;
            // color is applied where the masks are written
            CSR_PIXEL_COLOR:  ;
            default:          ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ACT_LOAD_GLYPH: begin
                     gt_we = ({1'b0, req_index} < GLYPH_LIMIT);
                  end
                  ACT_LOAD_BITMAP: begin
                     bm_we = ({1'b0, req_index} < BITMAP_LIMIT);
                  end
                  ACT_DRAW: begin
                     gt_re        = 1'b1;
                     glyph_vld_in = code_ok;
                     row_in       = req_row;
                     end_in       = req_tlast;
                     if (req_start) begin
                        cursor_in = 16'd0;
                     end
                     state_in = S_GLYPH;
                  end
                  default: ;
               endcase
            end
         end
         S_GLYPH: begin
            g_in       = g_rd;
            covered_in = (g_rd.width != 8'd0) && ($signed(row_s) >= $signed(fl)) &&
                         ($signed(row_s) < $signed(fl_top));
            rel_in     = rel_full[7:0];
            // negative first offset pushes a fresh cursor right
            if (g_rd.x_offset[7] && (cursor_ff == 16'd0)) begin
               cursor_in = 16'd0 - {{8{g_rd.x_offset[7]}}, g_rd.x_offset};
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            boff_in = {8'd0, g_ff.width} * {8'd0, rel_ff};
            pos_in  = cursor_ff + xo16;
            rem_in  = g_ff.width;
            if (end_ff && overhang) begin
               cursor_in = cursor_ff + {8'd0, g_ff.width} + xo16;
            end else begin
               cursor_in = cursor_ff + adv16;
            end
            state_in = covered_ff ? S_FETCH0 : S_RUN;
         end
         S_FETCH0: begin
            bm_re      = 1'b1;
            bm_raddr   = g_ff.bitmap_offset + {3'b000, boff_ff[15:3]};
            rd_addr_in = bm_raddr;
            rd_oob_in  = ({1'b0, bm_raddr} >= BITMAP_LIMIT);
            sh_in      = boff_ff[2:0];
            state_in   = S_FETCH1;
         end
         S_FETCH1: begin
            hi_in      = lo_byte;
            bm_re      = 1'b1;
            rd_addr_in = bm_raddr;
            rd_oob_in  = ({1'b0, bm_raddr} >= BITMAP_LIMIT);
            state_in   = S_RUN;
         end
         S_RUN: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               out_width_in = cursor_ff;
               if (!covered_ff) begin
                  // row outside the glyph or zero width: one empty word
                  out_byte_in = 13'd0;
                  out_mask_in = 8'd0;
                  out_last_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  out_byte_in = pos_ff[15:3];
                  out_mask_in = (shifted[15:8] & keep) >> pix;
                  out_last_in = take_last;
                  pos_in      = pos_ff + {12'd0, take};
                  rem_in      = rem_ff - {4'd0, take};
                  sh_in       = sh_sum[2:0];
                  // crossed into the next bitmap byte, fetch the one after
                  if (sh_sum[3]) begin
                     hi_in      = lo_byte;
                     bm_re      = 1'b1;
                     rd_addr_in = bm_raddr;
                     rd_oob_in  = ({1'b0, bm_raddr} >= BITMAP_LIMIT);
                  end
                  if (take_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_code_ff <= FIRST_CODE_RESET;
         last_code_ff  <= LAST_CODE_RESET;
         min_y_ff      <= 8'd0;
         cursor_ff     <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_code_ff <= first_code_in;
         last_code_ff  <= last_code_in;
         min_y_ff      <= min_y_in;
         cursor_ff     <= cursor_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_mask_ff  <= out_mask_in;
      out_width_ff <= out_width_in;
      out_last_ff  <= out_last_in;
      glyph_vld_ff <= glyph_vld_in;
      row_ff       <= row_in;
      end_ff       <= end_in;
      g_ff         <= g_in;
      covered_ff   <= covered_in;
      rel_ff       <= rel_in;
      boff_ff      <= boff_in;
      pos_ff       <= pos_in;
      rem_ff       <= rem_in;
      sh_ff        <= sh_in;
      hi_ff        <= hi_in;
      rd_addr_ff   <= rd_addr_in;
      rd_oob_ff    <= rd_oob_in;
   end

   assign rsp_tdata  = {3'b000, out_width_ff, out_mask_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_run_has_pixels: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && covered_ff) |-> (rem_ff != 8'd0))
      else $error("byte walk running with no pixels left");

   a_last_ends_draw: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_last_in) |=> (state_ff == S_IDLE && rsp_tvalid && rsp_tlast))
      else $error("final word did not end the draw");

   a_setup_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GLYPH) |=> (state_ff == S_MUL))
      else $error("draw setup out of order");

   a_store_write_idle: assert property (@(posedge clock) disable iff (reset)
      (bm_we || gt_we) |-> (state_ff == S_IDLE && !bm_re))
      else $error("store written during a draw");
`endif

endmodule

// File: verif/glyph_row_rasterizer_unit_tb.sv
// ---------------------------------------------------------------------------
// glyph_row_rasterizer_unit_tb
// Self-checking bench for the glyph row rasterizer. Glyph descriptors and
// bitmap bytes are loaded over the request stream, then characters are drawn
// and every response word (byte index, mask, line width, tlast) is compared
// with a behavioral rasterizer kept in the bench. Draws only ever touch
// glyph slots and bitmap bytes that were loaded before.
// ---------------------------------------------------------------------------
module glyph_row_rasterizer_unit_tb;
   import grr_pkg::*;

   localparam int GLYPH_SLOTS  = GLYPH_SLOTS_DEFAULT;
   localparam int BITMAP_BYTES = BITMAP_BYTES_DEFAULT;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int FONT_REGION  = 40;     // bitmap bytes preloaded from address 0
   localparam int QUIET_CYCLES = 48;
   localparam int STALL_LIMIT  = 4000;

   typedef struct {
      logic [1:0]     action;
      logic [15:0]    index;
      glyph_desc_type desc;
      logic [7:0]     row;
      logic           str_first;
      logic           str_last;
   } glyph_request_t;

   typedef struct {
      logic [12:0] byte_index;
      logic [7:0]  bit_mask;
      logic [15:0] line_width;
      logic        is_last;
   } mask_word_t;

   logic        clock;
   logic        reset;
   logic [79:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        req_tlast;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   // rasterizer state as the bench sees it
   glyph_desc_type glyph_mem [GLYPH_SLOTS];
   bit             glyph_loaded [GLYPH_SLOTS];
   logic [7:0]     bitmap_mem [BITMAP_BYTES];
   bit             bitmap_loaded [BITMAP_BYTES];
   logic [15:0]    pen_x = '0;
   int             cfg_first = FIRST_CODE_RESET;
   int             cfg_last = LAST_CODE_RESET;
   int             min_y_off = 0;
   logic           pixel_on = 1'b1;   // only steers the line-buffer writer

   mask_word_t mask_words_due [$];
   int         mismatch_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         stall_cycles = 0;
   int         chars_left = 0;
   int         str_pos = 0;
   logic [7:0] string_row = '0;

   glyph_row_rasterizer_unit #(
      .GLYPH_SLOTS (GLYPH_SLOTS),
      .BITMAP_BYTES(BITMAP_BYTES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------
   function automatic logic [7:0] bitmap_byte(int addr);
      return (addr < BITMAP_BYTES) ? bitmap_mem[addr] : 8'h00;
   endfunction

   // glyph slot a character resolves to, -1 for the blank glyph
   function automatic int glyph_slot_of(logic [15:0] code_in);
      int code;
      code = int'(code_in);
      if (code < cfg_first || code > cfg_last) code = int'(SPACE_CODE);
      if (code >= cfg_first && code <= cfg_last && code - cfg_first < GLYPH_SLOTS)
         return code - cfg_first;
      return -1;
   endfunction

   // true when every bitmap byte the row walk may read has been loaded
   function automatic bit row_fetch_loaded(glyph_desc_type g, logic [7:0] row);
      int fl, boff, addr, nbytes, i;
      fl = int'($signed(g.y_offset)) - min_y_off;
      if (g.width == 0 || int'(row) < fl || int'(row) >= fl + int'(g.height)) return 1'b1;
      boff = int'(g.width) * (int'(row) - fl);
      addr = int'(g.bitmap_offset) + (boff >> 3);
      nbytes = ((boff & 7) + int'(g.width) + 7) / 8 + 2;
      for (i = 0; i < nbytes; i++) begin
         if (((addr + i) & 'hFFFF) < BITMAP_BYTES && !bitmap_loaded[(addr + i) & 'hFFFF])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic rasterize_request(input glyph_request_t rq);
      glyph_desc_type g;
      mask_word_t     words [$];
      mask_word_t     mw;
      int slot, xo, adv, fl, r, w, boff, addr, bits, bitpos, start, p, k, n;
      case (rq.action)
         ACT_LOAD_GLYPH: begin
            if (rq.index < GLYPH_SLOTS) begin
               glyph_mem[rq.index] = rq.desc;
               glyph_loaded[rq.index] = 1'b1;
            end
         end
         ACT_LOAD_BITMAP: begin
            if (rq.index < BITMAP_BYTES) begin
               bitmap_mem[rq.index] = rq.desc.width;
               bitmap_loaded[rq.index] = 1'b1;
            end
         end
         ACT_DRAW: begin
            if (rq.str_first) pen_x = '0;
            slot = glyph_slot_of(rq.index);
            g = (slot >= 0) ? glyph_mem[slot] : '0;
            xo = int'($signed(g.x_offset));
            adv = int'($signed(g.advance));
            w = int'(g.width);
            if (xo < 0 && pen_x == 0) pen_x = 16'(-xo);
            fl = int'($signed(g.y_offset)) - min_y_off;
            r = int'(rq.row);
            if (w > 0 && r >= fl && r < fl + int'(g.height)) begin
               boff = w * (r - fl);
               addr = (int'(g.bitmap_offset) + (boff >> 3)) & 'hFFFF;
               bitpos = boff & 7;
               bits = (int'(bitmap_byte(addr)) << bitpos) & 'hFF;
               start = int'(pen_x) + xo;
               for (k = 0; k < w; k++) begin
                  p = (start + k) & 'hFFFF;
                  n = words.size();
                  if (n == 0 || (p >> 3) != int'(words[n - 1].byte_index)) begin
                     mw.byte_index = 13'(p >> 3);
                     mw.bit_mask = '0;
                     mw.line_width = '0;
                     mw.is_last = 1'b0;
                     words.push_back(mw);
                     n = words.size();
                  end
                  if (bits & 'h80) words[n - 1].bit_mask |= 8'h80 >> (p & 7);
                  bits = (bits << 1) & 'hFF;
                  bitpos++;
                  if (bitpos == 8) begin
                     bitpos = 0;
                     addr = (addr + 1) & 'hFFFF;
                     bits = int'(bitmap_byte(addr));
                  end
               end
            end
            pen_x = pen_x + 16'(adv);
            // overhang of the last glyph of a string
            if (rq.str_last && w + xo > adv) pen_x = pen_x + 16'(w + xo - adv);
            if (words.size() == 0) begin
               mw.byte_index = '0;
               mw.bit_mask = '0;
               words.push_back(mw);
            end
            foreach (words[i]) begin
               words[i].line_width = pen_x;
               words[i].is_last = (i == words.size() - 1);
               mask_words_due.push_back(words[i]);
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic glyph_desc_type make_desc(int off, int w, int h, int adv, int xo, int yo);
      glyph_desc_type d;
      d.bitmap_offset = 16'(off);
      d.width = 8'(w);
      d.height = 8'(h);
      d.advance = 8'(adv);
      d.x_offset = 8'(xo);
      d.y_offset = 8'(yo);
      return d;
   endfunction

   function automatic glyph_desc_type random_desc();
      return make_desc($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // random glyph whose row walk stays on loaded bitmap bytes
   function automatic glyph_desc_type safe_glyph_for_row(logic [7:0] row);
      glyph_desc_type g;
      int tries, h, yo, pick, wpick;
      for (tries = 0; tries < 64; tries++) begin
         h = $urandom_range(1, 8);
         pick = $urandom_range(0, 9);
         wpick = $urandom_range(0, 9);
         g = random_desc();
         g.height = 8'(h);
         if (pick < 7) g.bitmap_offset = 16'($urandom_range(0, 15));
         else if (pick < 8) g.bitmap_offset = 16'(BITMAP_BYTES - int'($urandom_range(1, 4)));
         else g.bitmap_offset = 16'(16'hFFFF - int'($urandom_range(0, 3)));
         if (wpick < 8) g.width = 8'($urandom_range(1, 24));
         else if (wpick < 9) g.width = 8'd0;
         else g.width = 8'($urandom_range(25, 255));
         if ($urandom_range(0, 9) < 7) begin
            yo = int'(row) - int'($urandom_range(0, h - 1)) + min_y_off;
            if (yo >= -128 && yo <= 127) g.y_offset = 8'(yo);
         end
         if (row_fetch_loaded(g, row)) return g;
      end
      g.width = 8'd0;
      return g;
   endfunction

   function automatic glyph_request_t make_req(logic [1:0] action, logic [15:0] index,
                                               glyph_desc_type desc, logic [7:0] row,
                                               logic str_first, logic str_last);
      glyph_request_t rq;
      rq.action = action;
      rq.index = index;
      rq.desc = desc;
      rq.row = row;
      rq.str_first = str_first;
      rq.str_last = str_last;
      return rq;
   endfunction

   task automatic send_request(input glyph_request_t rq);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {rq.row, rq.desc, rq.index};
      req_tuser <= {rq.str_first, rq.action};
      req_tlast <= rq.str_last;
      req_tvalid <= 1'b1;
      rasterize_request(rq);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_glyph(input logic [15:0] slot, input glyph_desc_type d);
      send_request(make_req(ACT_LOAD_GLYPH, slot, d, 8'($urandom), $urandom, $urandom));
   endtask

   task automatic load_bitmap(input logic [15:0] addr, input logic [7:0] data);
      glyph_desc_type d;
      d = random_desc();
      d.width = data;
      send_request(make_req(ACT_LOAD_BITMAP, addr, d, 8'($urandom), $urandom, $urandom));
   endtask

   // draws a character, first (re)loading its glyph when the row walk
   // would hit an unloaded slot or bitmap byte
   task automatic draw_text_char(input logic [15:0] code, input logic [7:0] row,
                                 input logic str_first, input logic str_last);
      int slot;
      slot = glyph_slot_of(code);
      if (slot >= 0 && (!glyph_loaded[slot] || !row_fetch_loaded(glyph_mem[slot], row)))
         load_glyph(16'(slot), safe_glyph_for_row(row));
      send_request(make_req(ACT_DRAW, code, random_desc(), row, str_first, str_last));
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (mask_words_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_FIRST_CODE:   cfg_first = int'(data);
         CSR_LAST_CODE:    cfg_last = int'(data);
         CSR_MIN_Y_OFFSET: min_y_off = int'($signed(data));
         CSR_PIXEL_COLOR:  pixel_on = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic prefill_bitmaps();
      int a;
      for (a = 0; a < FONT_REGION; a++) load_bitmap(16'(a), 8'($urandom));
      for (a = BITMAP_BYTES - 4; a < BITMAP_BYTES; a++) load_bitmap(16'(a), 8'($urandom));
   endtask

   task automatic test_basic_draw();
      load_glyph(16'd33, make_desc(0, 5, 7, 6, 0, 0));
      draw_text_char(16'h41, 8'd2, 1'b1, 1'b0);
      draw_text_char(16'h41, 8'd200, 1'b0, 1'b0);   // row outside the glyph
   endtask

   task automatic test_space_substitution();
      load_glyph(16'd0, make_desc(4, 3, 2, 4, -2, 1));
      draw_text_char(16'hFFFF, 8'd1, 1'b1, 1'b0);   // negative x offset at zero cursor
      draw_text_char(16'd31, 8'd2, 1'b0, 1'b0);
   endtask

   task automatic test_overhang();
      load_glyph(16'd34, make_desc(8, 20, 3, 10, 3, 0));
      draw_text_char(16'h42, 8'd2, 1'b0, 1'b1);
   endtask

   task automatic test_ignored_words();
      load_glyph(16'hFFFF, make_desc(-1, -1, -1, -1, -1, -1));
      load_glyph(16'(GLYPH_SLOTS), make_desc(-1, -1, -1, -1, -1, -1));
      load_bitmap(16'hFFFF, 8'hFF);
      load_bitmap(16'(BITMAP_BYTES), 8'hFF);
      send_request(make_req(ACT_UNUSED, 16'hFFFF, make_desc(-1, -1, -1, -1, -1, -1),
                            8'hFF, 1'b1, 1'b1));
      draw_text_char(16'h41, 8'd3, 1'b0, 1'b0);
   endtask

   task automatic test_wide_glyph();
      // 255 pixels from x 127 touch 33 bytes; advance -128 wraps the cursor
      load_glyph(16'd35, make_desc(0, 255, 1, -128, 127, 0));
      draw_text_char(16'h43, 8'd0, 1'b1, 1'b0);
      draw_text_char(16'h43, 8'd0, 1'b0, 1'b1);
   endtask

   task automatic test_store_wrap();
      // first byte beyond the store, then address wraps to zero
      load_glyph(16'd36, make_desc(16'hFFFF, 16, 1, 9, 0, 5));
      draw_text_char(16'h44, 8'd5, 1'b1, 1'b1);
   endtask

   task automatic test_register_extremes();
      wait_quiet();
      write_csr(CSR_FIRST_CODE, 8'd0);
      write_csr(CSR_LAST_CODE, 8'd255);
      write_csr(CSR_MIN_Y_OFFSET, 8'h80);
      write_csr(CSR_PIXEL_COLOR, 8'd0);
      draw_text_char(16'd0, 8'd0, 1'b1, 1'b0);
      draw_text_char(16'd255, 8'd255, 1'b0, 1'b0);
      draw_text_char(16'h0100, 8'd3, 1'b0, 1'b1);
      wait_quiet();
      // empty code range: every character becomes the blank glyph
      write_csr(CSR_FIRST_CODE, 8'd255);
      write_csr(CSR_LAST_CODE, 8'd0);
      draw_text_char(16'h41, 8'd2, 1'b1, 1'b0);
      draw_text_char(SPACE_CODE, 8'd2, 1'b0, 1'b1);
      wait_quiet();
      write_csr(CSR_FIRST_CODE, 8'd200);
      write_csr(CSR_LAST_CODE, 8'd255);
      write_csr(CSR_MIN_Y_OFFSET, 8'h7F);
      write_csr(CSR_PIXEL_COLOR, 8'd1);
      draw_text_char(16'd210, 8'd250, 1'b1, 1'b0);
      draw_text_char(16'd5, 8'd250, 1'b0, 1'b1);
      wait_quiet();
      write_csr(CSR_FIRST_CODE, FIRST_CODE_RESET);
      write_csr(CSR_LAST_CODE, LAST_CODE_RESET);
      write_csr(CSR_MIN_Y_OFFSET, 8'd0);
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      int i, sel;
      logic [15:0] code;
      logic str_first, str_last;
      wait_quiet();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_csr(CSR_FIRST_CODE, 8'($urandom_range(0, 48)));
      write_csr(CSR_LAST_CODE, 8'($urandom_range(64, 255)));
      write_csr(CSR_MIN_Y_OFFSET, 8'(int'($urandom_range(0, 16)) - 8));
      write_csr(CSR_PIXEL_COLOR, 8'($urandom_range(0, 1)));
      for (i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            // strings of a few characters on one row
            if (chars_left == 0) begin
               chars_left = $urandom_range(1, 6);
               str_pos = 0;
               string_row = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
            end
            str_first = (str_pos == 0);
            str_last = (chars_left == 1);
            if ($urandom_range(0, 9) == 0) begin
               str_first = $urandom;
               str_last = $urandom;
            end
            if ($urandom_range(0, 9) == 0) code = 16'($urandom);
            else code = 16'($urandom_range(cfg_first, cfg_last));
            draw_text_char(code, string_row, str_first, str_last);
            chars_left--;
            str_pos++;
         end else if (sel < 75) begin
            if ($urandom_range(0, 9) == 0) load_bitmap(16'($urandom_range(BITMAP_BYTES, 65535)),
                                                       8'($urandom));
            else load_bitmap(16'($urandom_range(0, FONT_REGION - 1)), 8'($urandom));
         end else if (sel < 88) begin
            if ($urandom_range(0, 9) == 0) load_glyph(16'($urandom_range(GLYPH_SLOTS, 65535)),
                                                      random_desc());
            else load_glyph(16'($urandom_range(0, GLYPH_SLOTS - 1)), random_desc());
         end else if (sel < 94) begin
            send_request(make_req(ACT_UNUSED, 16'($urandom), random_desc(), 8'($urandom),
                                  $urandom, $urandom));
         end else begin
            load_bitmap(16'(BITMAP_BYTES - int'($urandom_range(1, 4))), 8'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // response check and watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      mask_word_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mask_words_due.size() == 0) begin
            $error("unexpected rsp word: byte_index %0d bit_mask %02h line_width %0d",
                   rsp_tdata[12:0], rsp_tdata[20:13], rsp_tdata[36:21]);
            mismatch_count++;
         end else begin
            want = mask_words_due.pop_front();
            if (rsp_tdata[12:0] !== want.byte_index) begin
               $error("byte_index: expected %0d, got %0d", want.byte_index, rsp_tdata[12:0]);
               mismatch_count++;
            end
            if (rsp_tdata[20:13] !== want.bit_mask) begin
               $error("bit_mask: expected %02h, got %02h", want.bit_mask, rsp_tdata[20:13]);
               mismatch_count++;
            end
            if (rsp_tdata[36:21] !== want.line_width) begin
               $error("line_width: expected %0d, got %0d", want.line_width, rsp_tdata[36:21]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.is_last) begin
               $error("last: expected %0d, got %0d", want.is_last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 47;
      prefill_bitmaps();
      test_basic_draw();
      test_space_substitution();
      test_overhang();
      test_ignored_words();
      test_wide_glyph();
      test_store_wrap();
      test_register_extremes();
      test_random_traffic(40, 21, 47);
      test_random_traffic(40, 47, 21);
      test_random_traffic(40, 0, 0);
      wait_quiet();

      if (mask_words_due.size() != 0) begin
         $error("%0d expected rsp words never arrived", mask_words_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
